// File: design/qesc_pkg.sv
// ----------------------------------------------------------------------------
// Quad edge support check package
// Shared types, register indexes, engine states and defaults.
// ----------------------------------------------------------------------------
package qesc_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_WIDTH        = 512;
    localparam int DEF_MAX_HEIGHT       = 512;
    localparam int DEF_SAMPLES_PER_SIDE = 20;
    localparam int DEF_SEARCH_RADIUS    = 3;

    // Configuration port geometry.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Signed width of a window coordinate: a 9-bit point plus or minus the radius.
    localparam int CW = 11;

    localparam logic [9:0] RST_IMAGE_WIDTH   = 10'd512;
    localparam logic [9:0] RST_IMAGE_HEIGHT  = 10'd512;
    localparam logic [4:0] RST_MIN_SIDE_HITS = 5'd11;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_MIN_SIDE_HITS = 2'd2,
        REG_NONE          = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    typedef struct packed {
        logic       command;
        logic [8:0] pixel_x;
        logic [8:0] pixel_y;
        logic       pixel_edge;
        logic [8:0] corner0_x;
        logic [8:0] corner0_y;
        logic [8:0] corner1_x;
        logic [8:0] corner1_y;
        logic [8:0] corner2_x;
        logic [8:0] corner2_y;
        logic [8:0] corner3_x;
        logic [8:0] corner3_y;
    } in_t;

    typedef struct packed {
        logic [4:0] side0_hits;
        logic [4:0] side1_hits;
        logic [4:0] side2_hits;
        logic [4:0] side3_hits;
        logic [4:0] second_lowest_hits;
        logic       passes;
    } out_t;

    // A classified command as it sits in the queue between front and back.
    typedef struct packed {
        op_t op;
        in_t item;
    } cmd_t;

    // Queue head as the back end sees it.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qhead_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_WR_READ,
        B_WR_WRITE,
        B_SIDE,
        B_MUL,
        B_POINT,
        B_ROWS,
        B_LAST,
        B_DONE
    } bst_t;

endpackage

// File: design/qesc_ram.sv
// ----------------------------------------------------------------------------
// Quad edge support check RAM
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module qesc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/qesc_front.sv
// ----------------------------------------------------------------------------
// Quad edge support check front end
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module qesc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  qesc_pkg::in_t item,
    output qesc_pkg::qhead_t head,
    input  logic          head_pop
);
    import qesc_pkg::*;

    cmd_t       q_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;
    cmd_t       cmd_in;

    assign full    = (cnt_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = head_pop && (cnt_reg != 2'd0);

    always_comb
    begin
        cmd_in.item = item;
        cmd_in.op   = item.command ? OP_CHECK : OP_WRITE;
    end

    always_comb
    begin
        wptr_next = do_push ? !wptr_reg : wptr_reg;
        rptr_next = do_pop ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wptr_reg] <= cmd_in;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.cmd   = q_reg[rptr_reg];

endmodule

// File: design/qesc_back.sv
// ----------------------------------------------------------------------------
// Quad edge support check back end
// Executes pixel writes and quad checks against the row-organized bitmap.
// ----------------------------------------------------------------------------
module qesc_back #(
    parameter int MAX_WIDTH        = qesc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT       = qesc_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLES_PER_SIDE = qesc_pkg::DEF_SAMPLES_PER_SIDE,
    parameter int SEARCH_RADIUS    = qesc_pkg::DEF_SEARCH_RADIUS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  qesc_pkg::qhead_t head,
    output logic             head_pop,
    input  logic [9:0]       image_width,
    input  logic [9:0]       image_height,
    input  logic [4:0]       min_side_hits,
    output logic             empty,
    input  logic             pop,
    output qesc_pkg::out_t   result
);
    import qesc_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int AW   = $clog2(MAX_HEIGHT);
    localparam int NW   = $clog2(SAMPLES_PER_SIDE * 512) + 1;
    localparam int IW   = $clog2(SAMPLES_PER_SIDE + 1);
    localparam int CNTW = $clog2(SAMPLES_PER_SIDE + 2);
    localparam int WIN  = 2 * SEARCH_RADIUS + 1;
    localparam int RCW  = $clog2(2 * SEARCH_RADIUS + 2);
    localparam int PW   = NW + 33;
    // Rounded-up reciprocal of the sample count, scaled by 2^32.
    localparam logic [63:0] RECIP64 =
        ((64'd1 << 32) + 64'(SAMPLES_PER_SIDE) - 64'd1) / 64'(SAMPLES_PER_SIDE);
    localparam logic [32:0] RECIP    = RECIP64[32:0];
    localparam logic [12:0] MAXW13   = 13'(MAX_WIDTH);
    localparam logic [12:0] MAXH13   = 13'(MAX_HEIGHT);
    localparam logic [IW-1:0] LAST_I = IW'(SAMPLES_PER_SIDE);
    localparam logic [RCW-1:0] LAST_R = RCW'(2 * SEARCH_RADIUS);
    localparam logic [CW-1:0] RAD    = CW'(SEARCH_RADIUS);

    bst_t             state_reg, state_next;
    cmd_t             cmd_reg;
    logic [1:0]       side_reg;
    logic [IW-1:0]    idx_reg;
    logic [RCW-1:0]   rcnt_reg;
    logic [NW-1:0]    num_x_reg, num_y_reg, dif_x_reg, dif_y_reg;
    logic [PW-1:0]    prod_x_reg, prod_y_reg;
    logic [8:0]       sx_reg, sy_reg;
    logic             pend_reg, hit_reg;
    logic [CNTW-1:0]  cnt_reg [4];
    out_t             res_reg;
    logic             res_valid_reg;

    logic             ram_rd_en, ram_wr_en;
    logic [AW-1:0]    ram_rd_addr, ram_wr_addr;
    logic [MAX_WIDTH-1:0] ram_rd_data, ram_wr_data;

    logic [8:0]       cx [4];
    logic [8:0]       cy [4];
    logic [8:0]       ax, ay, bx, by;
    logic [9:0]       w, h;
    logic [12:0]      w13, h13;
    logic [CW-1:0]    ny;
    logic [12:0]      ny13, py13, px13;
    logic             row_ok, px_ok;
    logic [WIN-1:0]   win_bits;
    logic             win_any, hit_now;
    logic [CNTW-1:0]  lo1, hi1, lo2, hi2, mx, mn, second;

    qesc_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        cx[0] = cmd_reg.item.corner0_x;
        cy[0] = cmd_reg.item.corner0_y;
        cx[1] = cmd_reg.item.corner1_x;
        cy[1] = cmd_reg.item.corner1_y;
        cx[2] = cmd_reg.item.corner2_x;
        cy[2] = cmd_reg.item.corner2_y;
        cx[3] = cmd_reg.item.corner3_x;
        cy[3] = cmd_reg.item.corner3_y;
        ax = cx[side_reg];
        ay = cy[side_reg];
        bx = cx[side_reg + 2'd1];
        by = cy[side_reg + 2'd1];
    end

    // Image size clipped to the store.
    always_comb
    begin
        w13 = ({3'b000, image_width} > MAXW13) ? MAXW13 : {3'b000, image_width};
        h13 = ({3'b000, image_height} > MAXH13) ? MAXH13 : {3'b000, image_height};
        w   = w13[9:0];
        h   = h13[9:0];
    end

    // Row of the window being fetched, and the columns of the returned row.
    always_comb
    begin
        ny     = {2'b00, sy_reg} - RAD + CW'(rcnt_reg);
        ny13   = {2'b00, ny};
        row_ok = !ny[CW-1] && (ny[9:0] < h);
    end

    always_comb
    begin
        logic [CW-1:0] col;
        logic [12:0]   col13;
        for (int d = 0; d < WIN; d++)
        begin
            col         = {2'b00, sx_reg} - RAD + CW'(d);
            col13       = {2'b00, col};
            win_bits[d] = !col[CW-1] && (col[9:0] < w) && ram_rd_data[col13[XW-1:0]];
        end
        win_any = |win_bits;
        hit_now = hit_reg || (pend_reg && win_any);
    end

    always_comb
    begin
        px13  = {4'b0000, cmd_reg.item.pixel_x};
        py13  = {4'b0000, cmd_reg.item.pixel_y};
        px_ok = (px13 < MAXW13) && (py13 < MAXH13);
        ram_wr_data = ram_rd_data;
        ram_wr_data[px13[XW-1:0]] = cmd_reg.item.pixel_edge;
        ram_wr_addr = py13[AW-1:0];
    end

    // Second smallest of four counts.
    always_comb
    begin
        lo1    = (cnt_reg[0] < cnt_reg[1]) ? cnt_reg[0] : cnt_reg[1];
        hi1    = (cnt_reg[0] < cnt_reg[1]) ? cnt_reg[1] : cnt_reg[0];
        lo2    = (cnt_reg[2] < cnt_reg[3]) ? cnt_reg[2] : cnt_reg[3];
        hi2    = (cnt_reg[2] < cnt_reg[3]) ? cnt_reg[3] : cnt_reg[2];
        mx     = (lo1 > lo2) ? lo1 : lo2;
        mn     = (hi1 < hi2) ? hi1 : hi2;
        second = (mx < mn) ? mx : mn;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = (head.cmd.op == OP_WRITE) ? B_WR_READ : B_SIDE;
                end
            end
            B_WR_READ:  state_next = B_WR_WRITE;
            B_WR_WRITE: state_next = B_IDLE;
            B_SIDE:     state_next = B_MUL;
            B_MUL:      state_next = B_POINT;
            B_POINT:    state_next = B_ROWS;
            B_ROWS:
            begin
                if (rcnt_reg == LAST_R)
                begin
                    state_next = B_LAST;
                end
            end
            B_LAST:
            begin
                if (idx_reg != LAST_I)
                begin
                    state_next = B_MUL;
                end
                else if (side_reg == 2'd3)
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_SIDE;
                end
            end
            B_DONE:
            begin
                if (!res_valid_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            default:    state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        head_pop    = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = py13[AW-1:0];
        ram_wr_en   = 1'b0;
        case (state_reg)
            B_IDLE:     head_pop  = head.valid;
            B_WR_READ:  ram_rd_en = 1'b1;
            B_WR_WRITE: ram_wr_en = px_ok;
            B_ROWS:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ny13[AW-1:0];
            end
            default:
            begin
                head_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
            side_reg      <= 2'd0;
            idx_reg       <= '0;
            rcnt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
            else if (state_reg == B_DONE)
            begin
                res_valid_reg <= 1'b1;
            end
            case (state_reg)
                B_IDLE:  side_reg <= 2'd0;
                B_SIDE:  idx_reg  <= '0;
                B_POINT: rcnt_reg <= '0;
                B_ROWS:  rcnt_reg <= rcnt_reg + RCW'(1);
                B_LAST:
                begin
                    if (idx_reg != LAST_I)
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                    else
                    begin
                        side_reg <= side_reg + 2'd1;
                    end
                end
                default:
                begin
                    rcnt_reg <= rcnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    cmd_reg <= head.cmd;
                end
            end
            B_SIDE:
            begin
                num_x_reg <= NW'(SAMPLES_PER_SIDE) * {{(NW-9){1'b0}}, ax};
                num_y_reg <= NW'(SAMPLES_PER_SIDE) * {{(NW-9){1'b0}}, ay};
                dif_x_reg <= {{(NW-9){1'b0}}, bx} - {{(NW-9){1'b0}}, ax};
                dif_y_reg <= {{(NW-9){1'b0}}, by} - {{(NW-9){1'b0}}, ay};
                cnt_reg[side_reg] <= '0;
            end
            B_MUL:
            begin
                prod_x_reg <= PW'(num_x_reg) * PW'(RECIP);
                prod_y_reg <= PW'(num_y_reg) * PW'(RECIP);
            end
            B_POINT:
            begin
                sx_reg   <= prod_x_reg[32 +: 9];
                sy_reg   <= prod_y_reg[32 +: 9];
                pend_reg <= 1'b0;
                hit_reg  <= 1'b0;
            end
            B_ROWS:
            begin
                pend_reg <= row_ok;
                hit_reg  <= hit_now;
            end
            B_LAST:
            begin
                cnt_reg[side_reg] <= cnt_reg[side_reg] + CNTW'(hit_now);
                num_x_reg <= num_x_reg + dif_x_reg;
                num_y_reg <= num_y_reg + dif_y_reg;
            end
            B_DONE:
            begin
                if (!res_valid_reg)
                begin
                    res_reg.side0_hits         <= 5'(cnt_reg[0]);
                    res_reg.side1_hits         <= 5'(cnt_reg[1]);
                    res_reg.side2_hits         <= 5'(cnt_reg[2]);
                    res_reg.side3_hits         <= 5'(cnt_reg[3]);
                    res_reg.second_lowest_hits <= 5'(second);
                    res_reg.passes <= (8'(second) >= {3'b000, min_side_hits});
                end
            end
            default:
            begin
                hit_reg <= hit_reg;
            end
        endcase
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

endmodule

// File: design/quad_edge_support_check.sv
// ----------------------------------------------------------------------------
// Quad edge support check
// Edge bitmap store with a quad side support counter.
// ----------------------------------------------------------------------------
// A write beat stores one pixel of the edge bitmap in the back end with a row
// read, then a row write. A check beat samples SAMPLES_PER_SIDE+1 points on
// each of the four sides: every point first computes its position in a
// multiply step and a point step, then fetches 2*SEARCH_RADIUS+1 bitmap rows
// through the single read port of the bitmap RAM. A two-entry queue takes
// beats while the back end works, and one result register holds a finished
// result until it is popped. The bitmap is not cleared by reset; pixels must
// be written before a check looks at them.
module quad_edge_support_check #(
    parameter int MAX_WIDTH        = qesc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT       = qesc_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLES_PER_SIDE = qesc_pkg::DEF_SAMPLES_PER_SIDE,
    parameter int SEARCH_RADIUS    = qesc_pkg::DEF_SEARCH_RADIUS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  qesc_pkg::in_t                 item,
    output logic                          empty,
    input  logic                          pop,
    output qesc_pkg::out_t                result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qesc_pkg::PADDR_W-1:0]  paddr,
    input  logic [qesc_pkg::PDATA_W-1:0]  pwdata,
    output logic [qesc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import qesc_pkg::*;

    logic [9:0] image_width_reg;
    logic [9:0] image_height_reg;
    logic [4:0] min_side_hits_reg;
    logic       cfg_wr;
    reg_idx_t   reg_idx;
    qhead_t     head;
    logic       head_pop;

    // Registers sit on 32-bit boundaries; the word index selects one.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
            min_side_hits_reg <= RST_MIN_SIDE_HITS;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[9:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= pwdata[9:0];
                REG_MIN_SIDE_HITS: min_side_hits_reg <= pwdata[4:0];
                default:           image_width_reg   <= image_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IMAGE_WIDTH:   prdata = {22'd0, image_width_reg};
            REG_IMAGE_HEIGHT:  prdata = {22'd0, image_height_reg};
            REG_MIN_SIDE_HITS: prdata = {27'd0, min_side_hits_reg};
            default:           prdata = '0;
        endcase
    end

    // Front end: takes beats and queues them as classified commands.
    qesc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .head     (head),
        .head_pop (head_pop)
    );

    // Back end: runs writes and checks against the bitmap, one at a time.
    qesc_back #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_HEIGHT       (MAX_HEIGHT),
        .SAMPLES_PER_SIDE (SAMPLES_PER_SIDE),
        .SEARCH_RADIUS    (SEARCH_RADIUS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_pop      (head_pop),
        .image_width   (image_width_reg),
        .image_height  (image_height_reg),
        .min_side_hits (min_side_hits_reg),
        .empty         (empty),
        .pop           (pop),
        .result        (result)
    );

endmodule

// File: design/qesc_checker.sv
// ----------------------------------------------------------------------------
// Quad edge support check checker
// Port-level assertions on the result queue and configuration port.
// ----------------------------------------------------------------------------
module qesc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         empty,
    input logic                         pop,
    input qesc_pkg::out_t               result,
    input logic                         psel,
    input logic                         pready
);

    // The second-lowest count is always one of the four side counts.
    a_second_is_side: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.second_lowest_hits == result.side0_hits ||
                    result.second_lowest_hits == result.side1_hits ||
                    result.second_lowest_hits == result.side2_hits ||
                    result.second_lowest_hits == result.side3_hits))
        else $error("second-lowest count matches no side");

    // A popped result leaves the single result register empty in the next cycle.
    a_pop_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> empty)
        else $error("result register refilled in the pop cycle");

    // A waiting result holds until popped.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low");

endmodule

bind quad_edge_support_check qesc_checker u_qesc_checker (.*);

// File: test/quad_edge_support_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad edge support check testbench
// Streams pixel writes and quad checks through the queue ports under several
// image size settings and compares every result beat with a local predictor.
// ----------------------------------------------------------------------------
module quad_edge_support_check_tb;

    import qesc_pkg::*;

    localparam int STORE_W   = DEF_MAX_WIDTH;
    localparam int STORE_H   = DEF_MAX_HEIGHT;
    localparam int STEPS     = DEF_SAMPLES_PER_SIDE;
    localparam int RADIUS    = DEF_SEARCH_RADIUS;
    localparam int TAIL      = 50;
    localparam int CYCLE_CAP = 4000000;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    in_t                 beat_in;
    logic                empty;
    logic                pop;
    out_t                beat_out;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    quad_edge_support_check i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (beat_in),
        .empty   (empty),
        .pop     (pop),
        .result  (beat_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: the bitmap as the block should hold it, and the
    // register values that are in force.
    bit   edge_map [STORE_W*STORE_H];
    int   cfg_width  = 512;
    int   cfg_height = 512;
    int   cfg_min    = 11;

    // Pixels the stimulus has already written. fill_image writes every pixel
    // of the image in use that is not yet marked here.
    bit   written_map [STORE_W*STORE_H];

    in_t  pending_beats [$];
    out_t expected_support [$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   recv_hold_req = 0;
    int   mismatches    = 0;
    int   checks_seen   = 0;
    int   passes_seen   = 0;
    int   cycle_count   = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // True if any pixel inside the image lies within the square window
    // around the sample point.
    function automatic bit window_has_edge(int cx, int cy, int w, int h);
        int ny;
        int nx;
        for (int dy = -RADIUS; dy <= RADIUS; dy++)
        begin
            ny = cy + dy;
            if (ny < 0 || ny >= h)
                continue;
            for (int dx = -RADIUS; dx <= RADIUS; dx++)
            begin
                nx = cx + dx;
                if (nx < 0 || nx >= w)
                    continue;
                if (edge_map[ny*STORE_W + nx])
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Counts the sample points along one side that find an edge nearby.
    // The point position uses exact integer interpolation, so the
    // truncation matches the block's fixed-point walk.
    function automatic int side_support(int x1, int y1, int x2, int y2, int w, int h);
        int count;
        int sx;
        int sy;
        count = 0;
        for (int i = 0; i <= STEPS; i++)
        begin
            sx = ((STEPS - i)*x1 + i*x2) / STEPS;
            sy = ((STEPS - i)*y1 + i*y2) / STEPS;
            if (window_has_edge(sx, sy, w, h))
                count++;
        end
        return count;
    endfunction

    // Applies one accepted input beat to the predictor. A pixel write
    // updates the bitmap; a check returns its expected result.
    function automatic bit predict_support(in_t it, output out_t res);
        int cx [4];
        int cy [4];
        int hits [4];
        int srt [4];
        int w;
        int h;
        int t;
        res = '0;
        if (op_t'(it.command) == OP_WRITE)
        begin
            edge_map[it.pixel_y*STORE_W + it.pixel_x] = it.pixel_edge;
            return 1'b0;
        end
        // Registers above the store size are clamped to the store.
        w = (cfg_width  > STORE_W) ? STORE_W : cfg_width;
        h = (cfg_height > STORE_H) ? STORE_H : cfg_height;
        cx = '{it.corner0_x, it.corner1_x, it.corner2_x, it.corner3_x};
        cy = '{it.corner0_y, it.corner1_y, it.corner2_y, it.corner3_y};
        for (int k = 0; k < 4; k++)
        begin
            hits[k] = side_support(cx[k], cy[k], cx[(k+1)%4], cy[(k+1)%4], w, h);
            srt[k]  = hits[k];
        end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3 - a; b++)
                if (srt[b] > srt[b+1])
                begin
                    t        = srt[b];
                    srt[b]   = srt[b+1];
                    srt[b+1] = t;
                end
        res.side0_hits         = 5'(hits[0]);
        res.side1_hits         = 5'(hits[1]);
        res.side2_hits         = 5'(hits[2]);
        res.side3_hits         = 5'(hits[3]);
        res.second_lowest_hits = 5'(srt[1]);
        res.passes             = (srt[1] >= cfg_min);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers the oldest pending beat, idling at random. An offered
    // beat stays on the port unchanged until the block takes it.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        out_t res;
        bit   has_res;
        bit   taken;
        if (!rst_n)
        begin
            push    <= 1'b0;
            beat_in <= '0;
        end
        else
        begin
            taken = push && !full;
            if (taken)
            begin
                has_res = predict_support(pending_beats.pop_front(), res);
                if (has_res)
                    expected_support.insert(expected_support.size(), res);
            end
            if (push && !taken)
                ;
            else if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                push    <= 1'b1;
                beat_in <= pending_beats[0];
            end
            else
                push <= 1'b0;
        end
    end

    function automatic void report_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name,
                     exp_v, act_v);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: takes result beats, stalling at random or for a requested
    // long hold, and compares them field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        int   hold_left;
        out_t want;
        if (!rst_n)
        begin
            pop       <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_support.size() == 0)
                begin
                    $display("%0t: result beat with none expected: actual %p", $time,
                             beat_out);
                    mismatches++;
                end
                else
                begin
                    want = expected_support.pop_front();
                    checks_seen++;
                    if (want.passes)
                        passes_seen++;
                    report_field("side0_hits", want.side0_hits, beat_out.side0_hits);
                    report_field("side1_hits", want.side1_hits, beat_out.side1_hits);
                    report_field("side2_hits", want.side2_hits, beat_out.side2_hits);
                    report_field("side3_hits", want.side3_hits, beat_out.side3_hits);
                    report_field("second_lowest_hits", want.second_lowest_hits,
                                 beat_out.second_lowest_hits);
                    report_field("passes", want.passes, beat_out.passes);
                end
            end
            if (recv_hold_req > 0)
            begin
                hold_left     = recv_hold_req;
                recv_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The run ends here once the cycle count reaches CYCLE_CAP, as when the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("%0t: timeout with %0d beats pending and %0d results expected",
                     $time, pending_beats.size(), expected_support.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void queue_write(int x, int y, bit val);
        in_t it;
        it            = '0;
        it.command    = OP_WRITE;
        it.pixel_x    = 9'(x);
        it.pixel_y    = 9'(y);
        it.pixel_edge = val;
        // Corner 0 x and corner 3 y, which a write ignores, still carry random bits.
        it.corner0_x  = 9'($urandom);
        it.corner3_y  = 9'($urandom);
        written_map[y*STORE_W + x] = 1'b1;
        pending_beats.insert(pending_beats.size(), it);
    endfunction

    function automatic void queue_check(int x0, int y0, int x1, int y1,
                                        int x2, int y2, int x3, int y3);
        in_t it;
        it           = '0;
        it.command   = OP_CHECK;
        it.pixel_x   = 9'($urandom);
        it.pixel_y   = 9'($urandom);
        it.pixel_edge = 1'($urandom);
        it.corner0_x = 9'(x0);
        it.corner0_y = 9'(y0);
        it.corner1_x = 9'(x1);
        it.corner1_y = 9'(y1);
        it.corner2_x = 9'(x2);
        it.corner2_y = 9'(y2);
        it.corner3_x = 9'(x3);
        it.corner3_y = 9'(y3);
        pending_beats.insert(pending_beats.size(), it);
    endfunction

    // Writes every pixel of the image in use that has not been written yet,
    // so that checks never look at an undefined pixel.
    function automatic void fill_image(int density);
        int w;
        int h;
        w = (cfg_width  > STORE_W) ? STORE_W : cfg_width;
        h = (cfg_height > STORE_H) ? STORE_H : cfg_height;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                if (!written_map[y*STORE_W + x])
                    queue_write(x, y, $urandom_range(99) < density);
    endfunction

    // A corner coordinate near the image most of the time, else anywhere.
    function automatic int pick_coord(int span);
        int lim;
        lim = span + RADIUS + 1;
        if (lim > 511)
            lim = 511;
        if ($urandom_range(99) < 75)
            return $urandom_range(lim);
        return $urandom_range(511);
    endfunction

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || push || expected_support.size() != 0);
        // A trailing pixel write may still be in the back end.
        repeat (TAIL) @(posedge clk);
    endtask

    // One register write over the configuration port, setup then access.
    task automatic write_reg(reg_idx_t idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:   cfg_width  = value & 10'h3FF;
            REG_IMAGE_HEIGHT:  cfg_height = value & 10'h3FF;
            REG_MIN_SIDE_HITS: cfg_min    = value & 5'h1F;
            default: ;
        endcase
    endtask

    task automatic set_image(int w, int h, int min_hits);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_MIN_SIDE_HITS, min_hits);
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial
    begin
        int w;
        int h;
        int n_checks;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 50;

        // Directed part on a small, fully written image.
        set_image(16, 16, 11);
        fill_image(30);
        queue_write(0, 0, 1'b1);
        queue_write(15, 15, 1'b0);
        queue_write(511, 511, 1'b1);
        queue_write(511, 0, 1'b0);
        queue_check(0, 0, 0, 0, 0, 0, 0, 0);
        queue_check(511, 511, 511, 511, 511, 511, 511, 511);
        queue_check(0, 0, 15, 0, 15, 15, 0, 15);
        queue_check(0, 0, 511, 0, 511, 511, 0, 511);
        queue_check(15, 15, 0, 15, 0, 0, 15, 0);
        queue_check(2, 3, 12, 3, 12, 3, 2, 3);
        set_image(16, 16, 0);
        queue_check(0, 0, 15, 0, 15, 15, 0, 15);
        queue_check(511, 0, 511, 511, 0, 511, 0, 0);
        set_image(16, 16, 21);
        queue_check(0, 0, 15, 0, 15, 15, 0, 15);
        // A minimum beyond the sample count can never pass.
        set_image(16, 16, 31);
        queue_check(1, 1, 14, 1, 14, 14, 1, 14);

        // Widest image, one row high.
        set_image(512, 1, 0);
        fill_image(20);
        queue_check(0, 0, 511, 0, 511, 0, 0, 0);
        queue_check(0, 0, 511, 511, 0, 511, 511, 0);
        // Tallest image, one column wide. The corners stay in the top rows,
        // whose first column is already written.
        set_image(1, 512, 21);
        queue_check(0, 0, 0, 12, 0, 12, 0, 0);
        queue_check(0, 0, 0, 12, 511, 12, 511, 0);
        // Empty image: no pixel lies in the image and every count is zero.
        set_image(0, 5, 0);
        queue_check(0, 0, 3, 0, 3, 3, 0, 3);
        set_image(7, 0, 1);
        queue_check(0, 0, 3, 0, 3, 3, 0, 3);
        // Sizes above the store are clamped to it.
        set_image(1023, 1, 5);
        fill_image(15);
        queue_check(0, 0, 511, 1, 300, 0, 0, 1);

        // Random part: a new image setting per phase, then a mix of checks
        // and pixel writes.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 27;
            end
            if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(3) == 0)
            begin
                w = 512 + $urandom_range(1, 511) * $urandom_range(1);
                h = 1;
            end
            else
            begin
                w = $urandom_range(1, 24);
                h = $urandom_range(1, 16);
            end
            set_image(w, h, $urandom_range(31));
            fill_image($urandom_range(5, 60));
            n_checks = 0;
            for (int k = 0; k < 30; k++)
            begin
                if (ph == 2 && k == 10)
                begin
                    // Hold results back long enough that the block fills up
                    // and refuses further beats.
                    recv_hold_req = 6000;
                end
                if (ph == 5 && k == 15)
                begin
                    // Sender pauses until every result is in.
                    while (pending_beats.size() != 0 || push ||
                           expected_support.size() != 0)
                        @(posedge clk);
                end
                if ($urandom_range(99) < 55)
                begin
                    queue_check(pick_coord(w), pick_coord(h), pick_coord(w), pick_coord(h),
                                pick_coord(w), pick_coord(h), pick_coord(w), pick_coord(h));
                    n_checks++;
                end
                else if ($urandom_range(99) < 70)
                    queue_write($urandom_range((w > 512 ? 512 : w) - 1),
                                $urandom_range(h - 1), $urandom_range(1));
                else
                    queue_write($urandom_range(511), $urandom_range(511), $urandom_range(1));
                // Keep the beat queue short so that idling applies as issued.
                while (pending_beats.size() > 8)
                    @(posedge clk);
            end
        end

        wait_drained();
        $display("Covered %0d quad checks (%0d passing) over directed and random image",
                 checks_seen, passes_seen);
        $display("settings, including empty, clamped and single row or column images.");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
